// File: rtl/tcal_pkg.sv
// ----------------------------------------------------------------------------
// tcal_pkg
// Shared widths, constants, register codes, result type and month table for
// the tick calendar with start/stop key.
// ----------------------------------------------------------------------------
`default_nettype none

package tcal_pkg;

    // Calendar constants
    localparam int unsigned TICK_MS_DEF   = 100;
    localparam int unsigned MS_PER_SEC    = 1000;
    localparam int unsigned SEC_PER_MIN   = 60;
    localparam int unsigned MIN_PER_HOUR  = 60;
    localparam int unsigned HOUR_PER_DAY  = 24;
    localparam int unsigned MONTHS        = 12;
    localparam int unsigned YEAR_BASE     = 1980;
    localparam int unsigned YEAR_MAX      = 2107;
    localparam int unsigned LOCKOUT_DEF   = 100;

    // Field widths
    localparam int unsigned MS_W    = 10;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YOFF_W  = 7;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned LOCK_W  = 8;
    localparam int unsigned STAMP_W = 32;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_YEAR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 3'd6;

    // One result per tick
    typedef struct packed {
        logic               logging_on;
        logic               led_drive;
        logic [STAMP_W-1:0] fat_timestamp;
        logic [LOCK_W-1:0]  lockout_left;
    } t_result;

    // Days in a month, no leap years; code 0 reads as 0, codes 13 to 15 as 31
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        case (month)
            4'd0:    len = 5'd0;
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tcal_if.sv
// ----------------------------------------------------------------------------
// tcal_if
// Ready/valid channels: key tick requests in, calendar results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcal_key_if;
    logic valid;
    logic ready;
    logic key_level;

    modport source (output valid, output key_level, input ready);
    modport sink   (input valid, input key_level, output ready);
endinterface

interface tcal_res_if;
    logic                              valid;
    logic                              ready;
    logic                              logging_on;
    logic                              led_drive;
    logic [tcal_pkg::STAMP_W-1:0]      fat_timestamp;
    logic [tcal_pkg::LOCK_W-1:0]       lockout_left;

    modport source (output valid, output logging_on, output led_drive,
                    output fat_timestamp, output lockout_left, input ready);
    modport sink   (input valid, input logging_on, input led_drive,
                    input fat_timestamp, input lockout_left, output ready);
endinterface

`default_nettype wire

// File: rtl/tcal_core.sv
// ----------------------------------------------------------------------------
// tcal_core
// Preset writes, key debounce/toggle with lockout, and the calendar
// counter cascade. Gives the result of the tick being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module tcal_core #(
    parameter int unsigned TICK_MS = tcal_pkg::TICK_MS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_tick,
    input  logic                             i_key_level,
    input  logic                             i_cfg_we,
    input  logic [tcal_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcal_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tcal_pkg::t_result                o_result
);

    localparam int unsigned SUM_W = $clog2(tcal_pkg::MS_PER_SEC + TICK_MS);

    // Saturating loads from preset values
    function automatic logic [tcal_pkg::YOFF_W-1:0] clamp_year(
        input logic [tcal_pkg::YEAR_W-1:0] y);
        logic [tcal_pkg::YOFF_W-1:0] r;
        if (y < tcal_pkg::YEAR_W'(tcal_pkg::YEAR_BASE)) begin
            r = '0;
        end else if (y > tcal_pkg::YEAR_W'(tcal_pkg::YEAR_MAX)) begin
            r = '1;
        end else begin
            r = tcal_pkg::YOFF_W'(y - tcal_pkg::YEAR_W'(tcal_pkg::YEAR_BASE));
        end
        return r;
    endfunction

    function automatic logic [tcal_pkg::MONTH_W-1:0] clamp_month(
        input logic [tcal_pkg::MONTH_W-1:0] m);
        logic [tcal_pkg::MONTH_W-1:0] r;
        if (m == '0) begin
            r = 4'd1;
        end else if (m > tcal_pkg::MONTH_W'(tcal_pkg::MONTHS)) begin
            r = tcal_pkg::MONTH_W'(tcal_pkg::MONTHS);
        end else begin
            r = m;
        end
        return r;
    endfunction

    function automatic logic [tcal_pkg::DAY_W-1:0] clamp_day(
        input logic [tcal_pkg::DAY_W-1:0] d);
        return (d == '0) ? 5'd1 : d;
    endfunction

    function automatic logic [tcal_pkg::HOUR_W-1:0] clamp_hour(
        input logic [tcal_pkg::HOUR_W-1:0] h);
        return (h >= tcal_pkg::HOUR_W'(tcal_pkg::HOUR_PER_DAY))
               ? tcal_pkg::HOUR_W'(tcal_pkg::HOUR_PER_DAY - 1) : h;
    endfunction

    function automatic logic [tcal_pkg::SEC_W-1:0] clamp_60(
        input logic [tcal_pkg::SEC_W-1:0] v);
        return (v >= tcal_pkg::SEC_W'(tcal_pkg::SEC_PER_MIN))
               ? tcal_pkg::SEC_W'(tcal_pkg::SEC_PER_MIN - 1) : v;
    endfunction

    // Lockout preset; date and time presets act only at the write
    logic [tcal_pkg::LOCK_W-1:0]  r_p_lockout;

    // Clock and key state
    logic [tcal_pkg::MS_W-1:0]    r_millis,  n_millis;
    logic [tcal_pkg::SEC_W-1:0]   r_sec,     n_sec;
    logic [tcal_pkg::MIN_W-1:0]   r_min,     n_min;
    logic [tcal_pkg::HOUR_W-1:0]  r_hour,    n_hour;
    logic [tcal_pkg::DAY_W-1:0]   r_day,     n_day;
    logic [tcal_pkg::MONTH_W-1:0] r_month,   n_month;
    logic [tcal_pkg::YOFF_W-1:0]  r_yoff,    n_yoff;
    logic                         r_last_key, n_last_key;
    logic [tcal_pkg::LOCK_W-1:0]  r_lockout, n_lockout;
    logic                         r_logging, n_logging;

    logic [SUM_W-1:0] w_ms_sum;
    logic             w_sec_step, w_min_step, w_hour_step, w_day_step;
    logic             w_sec_wrap, w_min_wrap, w_hour_wrap;
    logic             w_month_end, w_year_end;

    // Key sampling and lockout
    always_comb begin
        n_last_key = r_last_key;
        n_logging  = r_logging;
        n_lockout  = r_lockout;
        if (r_lockout == '0) begin
            if (i_key_level != r_last_key) begin
                n_last_key = i_key_level;
            end else if (!i_key_level) begin
                n_logging = ~r_logging;
                n_lockout = r_p_lockout;
            end
        end else begin
            n_lockout = r_lockout - 1'b1;
        end
    end

    // Counter cascade: millis -> seconds -> minutes -> hours -> day -> month -> year
    assign w_ms_sum    = SUM_W'(r_millis) + SUM_W'(TICK_MS);
    assign w_sec_step  = (w_ms_sum >= SUM_W'(tcal_pkg::MS_PER_SEC));
    assign w_sec_wrap  = (r_sec  == tcal_pkg::SEC_W'(tcal_pkg::SEC_PER_MIN - 1));
    assign w_min_wrap  = (r_min  == tcal_pkg::MIN_W'(tcal_pkg::MIN_PER_HOUR - 1));
    assign w_hour_wrap = (r_hour == tcal_pkg::HOUR_W'(tcal_pkg::HOUR_PER_DAY - 1));
    assign w_min_step  = w_sec_step && w_sec_wrap;
    assign w_hour_step = w_min_step && w_min_wrap;
    assign w_day_step  = w_hour_step && w_hour_wrap;
    assign w_month_end = (r_day >= tcal_pkg::month_len(r_month));
    assign w_year_end  = (r_month >= tcal_pkg::MONTH_W'(tcal_pkg::MONTHS));

    always_comb begin
        n_millis = w_sec_step
                 ? tcal_pkg::MS_W'(w_ms_sum - SUM_W'(tcal_pkg::MS_PER_SEC))
                 : tcal_pkg::MS_W'(w_ms_sum);
        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_day   = r_day;
        n_month = r_month;
        n_yoff  = r_yoff;
        if (w_sec_step) begin
            n_sec = w_sec_wrap ? '0 : r_sec + 1'b1;
        end
        if (w_min_step) begin
            n_min = w_min_wrap ? '0 : r_min + 1'b1;
        end
        if (w_hour_step) begin
            n_hour = w_hour_wrap ? '0 : r_hour + 1'b1;
        end
        if (w_day_step) begin
            if (w_month_end) begin
                n_day = 5'd1;
                if (w_year_end) begin
                    n_month = 4'd1;
                    // year saturates at the top of the range
                    if (r_yoff != '1) begin
                        n_yoff = r_yoff + 1'b1;
                    end
                end else begin
                    n_month = r_month + 1'b1;
                end
            end else begin
                n_day = r_day + 1'b1;
            end
        end
    end

    // Result after this tick
    always_comb begin
        o_result.logging_on    = n_logging;
        o_result.led_drive     = n_logging;
        o_result.fat_timestamp = {n_yoff, n_month, n_day, n_hour, n_min,
                                  n_sec[tcal_pkg::SEC_W-1:1]};
        o_result.lockout_left  = n_lockout;
    end

    // State update: tick, or preset write (loads the clock when logging is off)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_lockout <= tcal_pkg::LOCK_W'(tcal_pkg::LOCKOUT_DEF);
            r_millis    <= '0;
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
            r_day       <= 5'd1;
            r_month     <= 4'd1;
            r_yoff      <= '0;
            r_last_key  <= 1'b0;
            r_lockout   <= '0;
            r_logging   <= 1'b0;
        end else if (i_tick) begin
            r_millis   <= n_millis;
            r_sec      <= n_sec;
            r_min      <= n_min;
            r_hour     <= n_hour;
            r_day      <= n_day;
            r_month    <= n_month;
            r_yoff     <= n_yoff;
            r_last_key <= n_last_key;
            r_lockout  <= n_lockout;
            r_logging  <= n_logging;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcal_pkg::CFG_YEAR: begin
                    if (!r_logging) r_yoff <= clamp_year(i_cfg_data);
                end
                tcal_pkg::CFG_MONTH: begin
                    if (!r_logging) begin
                        r_month <= clamp_month(i_cfg_data[tcal_pkg::MONTH_W-1:0]);
                    end
                end
                tcal_pkg::CFG_DAY: begin
                    if (!r_logging) r_day <= clamp_day(i_cfg_data[tcal_pkg::DAY_W-1:0]);
                end
                tcal_pkg::CFG_HOUR: begin
                    if (!r_logging) begin
                        r_hour <= clamp_hour(i_cfg_data[tcal_pkg::HOUR_W-1:0]);
                    end
                end
                tcal_pkg::CFG_MINUTE: begin
                    if (!r_logging) r_min <= clamp_60(i_cfg_data[tcal_pkg::MIN_W-1:0]);
                end
                tcal_pkg::CFG_SECOND: begin
                    if (!r_logging) r_sec <= clamp_60(i_cfg_data[tcal_pkg::SEC_W-1:0]);
                end
                tcal_pkg::CFG_LOCKOUT: begin
                    r_p_lockout <= i_cfg_data[tcal_pkg::LOCK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Checks
    a_millis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_millis < tcal_pkg::MS_W'(tcal_pkg::MS_PER_SEC))
        else $error("millisecond count out of range");

    a_lockout_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick && r_lockout != '0) |=> (r_lockout == $past(r_lockout) - 1'b1))
        else $error("lockout did not count down");

    a_toggle_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_logging)) |->
            $past(i_tick && r_lockout == '0 && !i_key_level))
        else $error("logging toggled outside a key press");

endmodule

`default_nettype wire

// File: rtl/tick_calendar_with_key_toggle_top.sv
// A result is registered in the result register, or in the skid while the
// output stalls. Throughput: one tick request per cycle while the skid is empty;
// the calendar cascade and key logic settle in one pass between the state
// registers and the result register. The two-entry output stage (result
// register plus skid) keeps input ready high while one result waits. Reset is
// synchronous, active low, and resets presets, clock, lockout, logging at once.
// ----------------------------------------------------------------------------
// tick_calendar_with_key_toggle_top
// Tick-driven calendar clock with a start/stop key that toggles logging.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_calendar_with_key_toggle_top #(
    parameter int unsigned TICK_MS = tcal_pkg::TICK_MS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tcal_key_if.sink                         i_key,
    tcal_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [tcal_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcal_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic              w_accept;
    tcal_pkg::t_result w_result;
    tcal_pkg::t_result r_out;
    tcal_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;

    assign i_key.ready = !r_skid_valid;
    assign w_accept    = i_key.valid && !r_skid_valid;

    tcal_core #(
        .TICK_MS (TICK_MS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_accept),
        .i_key_level (i_key.key_level),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_result    (w_result)
    );

    // Result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_res.ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
                if (w_accept) r_out <= w_result;
            end
        end else if (w_accept) begin
            r_skid       <= w_result;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.logging_on    = r_out.logging_on;
    assign o_res.led_drive     = r_out.led_drive;
    assign o_res.fat_timestamp = r_out.fat_timestamp;
    assign o_res.lockout_left  = r_out.lockout_left;

    // Checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output stage is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_res.ready))
        else $error("skid filled while the output stage could move");

endmodule

`default_nettype wire
